>>> hdl/mtca_pkg.sv
// Shared constants and types for the masked tile color average unit.
// No dependencies; imported by the front end, queue, back end and top level.
`timescale 1ns / 1ps
package mtca_pkg;

  localparam int PIX_W       = 8;
  localparam int MEAN_W      = 8;
  localparam int LANES       = 4;
  localparam int STEP_W      = $clog2(MEAN_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIX_W-1:0] OPAQUE_ALPHA = 8'd255;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_t;

endpackage

>>> hdl/mtca_front.sv
// Front end: accepts pixels, accumulates opaque channel sums and count,
// and pushes a tile summary into the queue on the tile's last pixel. Uses mtca_pkg.
`timescale 1ns / 1ps
module mtca_front #(
  parameter int MAX_TILE_PIXELS = 16384,
  localparam int SW = $clog2(255 * MAX_TILE_PIXELS + 1),
  localparam int CW = $clog2(MAX_TILE_PIXELS + 1),
  localparam int EW = 4 * SW + CW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  logic [mtca_pkg::PIX_W-1:0] pix_red,
  input  logic [mtca_pkg::PIX_W-1:0] pix_green,
  input  logic [mtca_pkg::PIX_W-1:0] pix_blue,
  input  logic [mtca_pkg::PIX_W-1:0] pix_alpha,
  input  logic                       tile_end,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic [EW-1:0]              q_data
);
  import mtca_pkg::*;

  logic [SW-1:0] sum_red, sum_green, sum_blue, sum_alpha;
  logic [SW-1:0] sum_red_next, sum_green_next, sum_blue_next, sum_alpha_next;
  logic [CW-1:0] opaque_count, opaque_count_next;
  logic          accept;
  logic          opaque;

  assign pix_ready = q_ready;
  assign accept    = pix_valid & pix_ready;

  // Stop counting once the tile has reached its pixel limit.
  assign opaque = (pix_alpha == OPAQUE_ALPHA) &&
                  (opaque_count < CW'(MAX_TILE_PIXELS));

  always_comb begin
    sum_red_next      = sum_red   + (opaque ? SW'(pix_red)   : '0);
    sum_green_next    = sum_green + (opaque ? SW'(pix_green) : '0);
    sum_blue_next     = sum_blue  + (opaque ? SW'(pix_blue)  : '0);
    sum_alpha_next    = sum_alpha + (opaque ? SW'(pix_alpha) : '0);
    opaque_count_next = opaque_count + CW'(opaque);
  end

  assign q_valid = accept & tile_end;
  assign q_data  = {opaque_count_next, sum_alpha_next, sum_blue_next,
                    sum_green_next, sum_red_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_red      <= '0;
      sum_green    <= '0;
      sum_blue     <= '0;
      sum_alpha    <= '0;
      opaque_count <= '0;
    end else if (accept) begin
      if (tile_end) begin
        sum_red      <= '0;
        sum_green    <= '0;
        sum_blue     <= '0;
        sum_alpha    <= '0;
        opaque_count <= '0;
      end else begin
        sum_red      <= sum_red_next;
        sum_green    <= sum_green_next;
        sum_blue     <= sum_blue_next;
        sum_alpha    <= sum_alpha_next;
        opaque_count <= opaque_count_next;
      end
    end
  end

endmodule

>>> hdl/mtca_queue.sv
// Two-entry queue of tile summaries between the front end and the divider.
// Uses mtca_pkg for depth and pointer widths.
`timescale 1ns / 1ps
module mtca_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import mtca_pkg::*;

  logic [WIDTH-1:0]   entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push, pop;

  assign in_ready  = (fill != QFILL_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + QFILL_W'(push) - QFILL_W'(pop);
    end
  end

endmodule

>>> hdl/mtca_back.sv
// Back end: restoring divider, one quotient bit per cycle on four channel
// lanes, computing floor((2*sum + count) / (2*count)), plus the output register. Uses mtca_pkg.
`timescale 1ns / 1ps
module mtca_back #(
  parameter int MAX_TILE_PIXELS = 16384,
  localparam int SW = $clog2(255 * MAX_TILE_PIXELS + 1),
  localparam int CW = $clog2(MAX_TILE_PIXELS + 1),
  localparam int EW = 4 * SW + CW,
  localparam int WW = $clog2(511 * MAX_TILE_PIXELS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [EW-1:0]               q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtca_pkg::MEAN_W-1:0] mean_red,
  output logic [mtca_pkg::MEAN_W-1:0] mean_green,
  output logic [mtca_pkg::MEAN_W-1:0] mean_blue,
  output logic [mtca_pkg::MEAN_W-1:0] mean_alpha,
  output logic                        no_opaque
);
  import mtca_pkg::*;

  back_state_t       state;
  logic [SW-1:0]     lane_sum [LANES];
  logic [CW-1:0]     tile_count;
  logic [WW-1:0]     rem      [LANES];
  logic [MEAN_W-1:0] quot     [LANES];
  logic [LANES-1:0]  fits;
  logic [WW-1:0]     dsh;
  logic [STEP_W-1:0] step;
  logic              empty;

  for (genvar l = 0; l < LANES; l++) begin : g_unpack
    assign lane_sum[l] = q_data[l*SW +: SW];
  end
  assign tile_count = q_data[LANES*SW +: CW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fits[l] = (rem[l] >= dsh);
    end
  end

  assign q_ready = (state == BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // Drop a taken result unless a new one replaces it in this cycle.
      if (out_valid && out_ready && state != BK_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (q_valid) begin
            for (int l = 0; l < LANES; l++) begin
              rem[l]  <= (WW'(lane_sum[l]) << 1) + WW'(tile_count);
              quot[l] <= '0;
            end
            // Divisor 2*count aligned to the top quotient bit.
            dsh   <= WW'(tile_count) << MEAN_W;
            empty <= (tile_count == '0);
            step  <= '0;
            state <= (tile_count == '0) ? BK_DONE : BK_DIV;
          end
        end
        BK_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            if (fits[l]) begin
              rem[l] <= rem[l] - dsh;
            end
            quot[l] <= {quot[l][MEAN_W-2:0], fits[l]};
          end
          dsh  <= dsh >> 1;
          step <= step + 1'b1;
          if (step == STEP_W'(MEAN_W - 1)) begin
            state <= BK_DONE;
          end
        end
        BK_DONE: begin
          // Load the output register once it is free or being drained.
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            mean_red   <= empty ? '0 : quot[0];
            mean_green <= empty ? '0 : quot[1];
            mean_blue  <= empty ? '0 : quot[2];
            mean_alpha <= empty ? '0 : quot[3];
            no_opaque  <= empty;
            state      <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/masked_tile_color_average_unit.sv
// Masked tile color average: top level joining front end, queue and divider.
// Depends on mtca_pkg, mtca_front, mtca_queue and mtca_back.
// Pixels: one per cycle while the two-entry tile queue has room.
// A tile result passes the queue, the divider load, eight division steps and
// the done state (empty tiles skip the steps); a tile is taken only when idle.
// Reset (rst, synchronous, active high) clears sums, count, queue and output.
`timescale 1ns / 1ps
module masked_tile_color_average_unit #(
  parameter int MAX_TILE_PIXELS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // pix_red, pix_green, pix_blue, pix_alpha
  input  logic        s_tlast,  // tile_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // mean_red, mean_green, mean_blue, mean_alpha
  output logic        m_tuser   // no_opaque
);
  import mtca_pkg::*;

  localparam int SW = $clog2(255 * MAX_TILE_PIXELS + 1);
  localparam int CW = $clog2(MAX_TILE_PIXELS + 1);
  localparam int EW = 4 * SW + CW;

  logic          fq_valid, fq_ready;
  logic [EW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [EW-1:0] qb_data;

  mtca_front #(.MAX_TILE_PIXELS(MAX_TILE_PIXELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pix_red   (s_tdata[7:0]),
    .pix_green (s_tdata[15:8]),
    .pix_blue  (s_tdata[23:16]),
    .pix_alpha (s_tdata[31:24]),
    .tile_end  (s_tlast),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  mtca_queue #(.WIDTH(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  mtca_back #(.MAX_TILE_PIXELS(MAX_TILE_PIXELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .mean_red   (m_tdata[7:0]),
    .mean_green (m_tdata[15:8]),
    .mean_blue  (m_tdata[23:16]),
    .mean_alpha (m_tdata[31:24]),
    .no_opaque  (m_tuser)
  );

endmodule

>>> hdl/mtca_checker.sv
// Port-level checks for masked_tile_color_average_unit, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module mtca_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result transaction holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An empty tile reports all-zero means.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("empty tile with nonzero means");

  // Only opaque pixels count, so the alpha mean of a non-empty tile is full.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:24] == 8'd255)
    else $error("alpha mean not opaque");

  // No result leaves right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind masked_tile_color_average_unit mtca_checker u_mtca_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
